FILE: design/cbb_pkg.sv
`default_nettype none

package cbb_pkg;

  // Number of live filter positions (8..64); port fields stay 64 bits wide
  localparam int unsigned FILTER_BITS = 64;
  localparam int unsigned FIELD_W     = 64;

  // Per-position reference counter
  localparam int unsigned CNT_W   = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Control that the top level broadcasts to every lane
  typedef struct packed {
    logic upd;     // request accepted and this lane's mask bit is set
    op_e  op;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: design/cbb_lane.sv
`default_nettype none

module cbb_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbb_pkg::lane_ctrl_t ctrl_i,
  output logic              bit_d_o
);
  import cbb_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bit_q, bit_d;

  // Saturating increment on add, floor-at-zero decrement on remove
  always_comb begin
    cnt_d = cnt_q;
    bit_d = bit_q;
    if (ctrl_i.upd) begin
      unique case (ctrl_i.op)
        OP_ADD: begin
          if (cnt_q != CNT_MAX) cnt_d = cnt_q + CNT_W'(1);
          bit_d = 1'b1;
        end
        OP_REMOVE: begin
          if (cnt_q != '0) cnt_d = cnt_q - CNT_W'(1);
          if (cnt_d == '0) bit_d = 1'b0;
        end
        default: begin
          cnt_d = cnt_q;
          bit_d = bit_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      bit_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      bit_q <= bit_d;
    end
  end

  // Next filter bit goes straight to the merge stage
  assign bit_d_o = bit_d;

endmodule

`default_nettype wire

FILE: design/cbb_merge.sv
`default_nettype none

module cbb_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [cbb_pkg::FILTER_BITS-1:0] bits_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [cbb_pkg::FIELD_W-1:0]   filter_bits_o,
  output logic                          free_o
);
  import cbb_pkg::*;

  logic               valid_q, valid_d;
  logic [FIELD_W-1:0] data_q;
  logic [FIELD_W-1:0] packed_bits;

  // Gather lane bits into the output word, unused positions read zero
  for (genvar j = 0; j < FIELD_W; j++) begin : g_pack
    if (j < FILTER_BITS) begin : g_live
      assign packed_bits[j] = bits_i[j];
    end else begin : g_dead
      assign packed_bits[j] = 1'b0;
    end
  end

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i)           valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result register, payload only
  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= packed_bits;
  end

  assign out_valid_o   = valid_q;
  assign filter_bits_o = data_q;

endmodule

`default_nettype wire

FILE: design/counting_bloom_bitmap.sv
`default_nettype none

// Counting Bloom filter over a FILTER_BITS-wide bitmap (cbb_pkg, default 64).
// Each request carries op (add or remove) and a 64-bit topic mask; every
// accepted request returns exactly one result, the filter bitmap after the
// update. One lane per position holds a saturating 16-bit reference counter
// and its filter bit; the lanes whose mask bit is set update in the cycle a
// request is accepted, and the merge stage registers the new bitmap. A request
// is accepted every cycle as long as the result register is empty or being
// drained; a stalled output holds off input. Mask bits at or above
// FILTER_BITS are ignored and the matching output bits are zero.
module counting_bloom_bitmap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [cbb_pkg::FIELD_W-1:0] topic_mask_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cbb_pkg::FIELD_W-1:0] filter_bits_o
);
  import cbb_pkg::*;

  logic                   accept;
  logic                   free;
  logic [FILTER_BITS-1:0] lane_bits;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  // Position lanes
  for (genvar i = 0; i < FILTER_BITS; i++) begin : g_lane
    lane_ctrl_t ctrl;
    assign ctrl.upd = accept && topic_mask_i[i];
    assign ctrl.op  = op_e'(op_i);

    cbb_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_d_o (lane_bits[i])
    );
  end

  // Merge lane bits into the result register
  cbb_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .bits_i        (lane_bits),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .filter_bits_o (filter_bits_o),
    .free_o        (free)
  );

endmodule

`default_nettype wire
